@@ rtl/core/accel_tilt_angles_core_macros.svh @@
// Assertion macros for the tilt angle core.
// Included by the top level; no other dependencies.
`ifndef ACCEL_TILT_ANGLES_CORE_MACROS_SVH
`define ACCEL_TILT_ANGLES_CORE_MACROS_SVH

// Assert a condition on every clock edge outside reset.
`define ATA_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Assert that an antecedent implies a consequent in the next cycle.
`define ATA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ata_pkg.sv @@
// Package for the tilt angle core: payload types, widths and the CORDIC angle table.
// No dependencies.
package ata_pkg;

  localparam int SampleBits = 12;
  localparam int AngleFracBits = 8;
  localparam int TableFrac = 24;
  localparam int CordicSteps = 28;
  localparam int SqBits = 2 * SampleBits;
  // Radicand is the sum of squares shifted left by 32 bits.
  localparam int RadBits = SqBits + 32;
  localparam int RootBits = RadBits / 2;
  // CORDIC x/y width: magnitude grows by ~1.65, y starts at n * 2^16.
  localparam int CordW = RootBits + 3;
  localparam int ZW = 32;
  localparam int AngleW = 16;
  localparam int RoundSh = TableFrac - AngleFracBits;
  localparam logic [ZW-1:0] FullAngle = ZW'(90) << AngleFracBits;

  typedef struct packed {
    logic signed [SampleBits-1:0] accel_x;
    logic signed [SampleBits-1:0] accel_y;
    logic signed [SampleBits-1:0] accel_z;
  } ata_in_t;

  typedef struct packed {
    logic signed [AngleW-1:0] roll_angle;
    logic signed [AngleW-1:0] pitch_angle;
  } ata_out_t;

  // Special-case flags that travel with one angle through the pipeline.
  typedef struct packed {
    logic zero_num;
    logic zero_mag;
    logic neg_num;
  } ata_flags_t;

  // atan(2^-i) in degrees, scaled by 2^24.
  function automatic logic [ZW-1:0] atan_deg(input logic [4:0] i);
    logic [ZW-1:0] t;
    case (i)
      5'd0: t = 32'd754974720;  5'd1: t = 32'd445687602;
      5'd2: t = 32'd235489088;  5'd3: t = 32'd119537938;
      5'd4: t = 32'd60000934;   5'd5: t = 32'd30029717;
      5'd6: t = 32'd15018523;   5'd7: t = 32'd7509720;
      5'd8: t = 32'd3754917;    5'd9: t = 32'd1877466;
      5'd10: t = 32'd938734;    5'd11: t = 32'd469367;
      5'd12: t = 32'd234684;    5'd13: t = 32'd117342;
      5'd14: t = 32'd58671;     5'd15: t = 32'd29335;
      5'd16: t = 32'd14668;     5'd17: t = 32'd7334;
      5'd18: t = 32'd3667;      5'd19: t = 32'd1833;
      5'd20: t = 32'd917;       5'd21: t = 32'd458;
      5'd22: t = 32'd229;       5'd23: t = 32'd115;
      5'd24: t = 32'd57;        5'd25: t = 32'd29;
      5'd26: t = 32'd14;        5'd27: t = 32'd7;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

@@ rtl/core/ata_sqrt.sv @@
// Pipelined integer square root, one result bit per stage, with sideband carried along.
// Depends on ata_pkg.
module ata_sqrt import ata_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [SqBits-1:0]           sq,
  input  logic signed [SampleBits-1:0] num,
  output logic                        out_valid,
  output logic [RootBits-1:0]         root,
  output logic signed [SampleBits-1:0] num_out
);

  // Restoring square root: stage k decides root bit RootBits-1-k.
  logic [RootBits:0]           valid;
  logic [RadBits-1:0]          rad [RootBits+1];
  logic [RootBits-1:0]         rt  [RootBits+1];
  logic [RadBits+1:0]          rem [RootBits+1];
  logic signed [SampleBits-1:0] nm [RootBits+1];

  always_comb begin
    valid[0] = in_valid;
    rad[0]   = {sq, 32'd0};
    rt[0]    = '0;
    rem[0]   = '0;
    nm[0]    = num;
  end

  for (genvar k = 0; k < RootBits; k++) begin : g_stage
    logic [RadBits+1:0] rem_sh;
    logic [RadBits+1:0] trial;
    always_comb begin
      rem_sh = {rem[k][RadBits-1:0], rad[k][RadBits-1 -: 2]};
      trial  = {{(RadBits-RootBits){1'b0}}, rt[k], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k+1] <= 1'b0;
      end else if (en) begin
        valid[k+1] <= valid[k];
      end
      if (en) begin
        rad[k+1] <= rad[k] << 2;
        nm[k+1]  <= nm[k];
        if (rem_sh >= trial) begin
          rem[k+1] <= rem_sh - trial;
          rt[k+1]  <= {rt[k][RootBits-2:0], 1'b1};
        end else begin
          rem[k+1] <= rem_sh;
          rt[k+1]  <= {rt[k][RootBits-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = valid[RootBits];
  assign root      = rt[RootBits];
  assign num_out   = nm[RootBits];

endmodule

@@ rtl/core/ata_cordic.sv @@
// Pipelined vectoring CORDIC with rounding and clamping to a 16-bit angle.
// Depends on ata_pkg.
module ata_cordic import ata_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [RootBits-1:0]         mag,
  input  logic signed [SampleBits-1:0] num,
  output logic                        out_valid,
  output logic signed [AngleW-1:0]    angle
);

  logic [CordicSteps:0]        valid;
  logic signed [CordW-1:0]     xs [CordicSteps+1];
  logic signed [CordW-1:0]     ys [CordicSteps+1];
  logic signed [ZW-1:0]        zs [CordicSteps+1];
  ata_flags_t                  fl [CordicSteps+1];

  always_comb begin
    valid[0]       = in_valid;
    xs[0]          = CordW'(mag);
    ys[0]          = CordW'(num) <<< 16;
    zs[0]          = '0;
    fl[0].zero_num = (num == '0);
    fl[0].zero_mag = (mag == '0);
    fl[0].neg_num  = num[SampleBits-1];
  end

  // One micro-rotation per stage; arithmetic shifts round toward minus infinity.
  for (genvar i = 0; i < CordicSteps; i++) begin : g_rot
    logic signed [CordW-1:0] dx;
    logic signed [CordW-1:0] dy;
    always_comb begin
      dx = ys[i] >>> i;
      dy = xs[i] >>> i;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        valid[i+1] <= 1'b0;
      end else if (en) begin
        valid[i+1] <= valid[i];
      end
      if (en) begin
        fl[i+1] <= fl[i];
        if (!ys[i][CordW-1]) begin
          xs[i+1] <= xs[i] + dx;
          ys[i+1] <= ys[i] - dy;
          zs[i+1] <= zs[i] + $signed(atan_deg(5'(i)));
        end else begin
          xs[i+1] <= xs[i] - dx;
          ys[i+1] <= ys[i] + dy;
          zs[i+1] <= zs[i] - $signed(atan_deg(5'(i)));
        end
      end
    end
  end

  // Round magnitude to nearest (ties away from zero), clamp, restore sign; zero num gives 0, zero mag +/-90.
  logic signed [ZW-1:0] z;
  logic [ZW-1:0]        zmag;
  logic [ZW-1:0]        rmag;
  logic [ZW-1:0]        cmag;
  logic signed [ZW-1:0] res;
  ata_flags_t           f;

  always_comb begin
    z    = zs[CordicSteps];
    f    = fl[CordicSteps];
    zmag = z[ZW-1] ? ZW'(-z) : ZW'(z);
    rmag = (zmag + (ZW'(1) << (RoundSh - 1))) >> RoundSh;
    cmag = (rmag > FullAngle) ? FullAngle : rmag;
    if (f.zero_num) begin
      res = '0;
    end else if (f.zero_mag) begin
      res = f.neg_num ? -$signed(FullAngle) : $signed(FullAngle);
    end else begin
      res = z[ZW-1] ? -$signed(cmag) : $signed(cmag);
    end
  end

  assign out_valid = valid[CordicSteps];
  assign angle     = res[AngleW-1:0];

endmodule

@@ rtl/core/ata_tilt.sv @@
// One tilt angle: sum of squares, square root pipeline, then CORDIC pipeline.
// Depends on ata_pkg, ata_sqrt and ata_cordic.
module ata_tilt import ata_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic signed [SampleBits-1:0] n,
  input  logic signed [SampleBits-1:0] p,
  input  logic signed [SampleBits-1:0] q,
  output logic                        out_valid,
  output logic signed [AngleW-1:0]    angle
);

  // Squares are registered before the adder feeds the root pipeline.
  logic                         sq_valid;
  logic [SqBits-1:0]            psq;
  logic [SqBits-1:0]            qsq;
  logic signed [SampleBits-1:0] n_q;
  logic [SqBits-1:0]            sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else if (en) begin
      sq_valid <= in_valid;
    end
    if (en) begin
      psq <= SqBits'(p) * SqBits'(p);
      qsq <= SqBits'(q) * SqBits'(q);
      n_q <= n;
    end
  end

  assign sum = psq + qsq;

  logic                         rt_valid;
  logic [RootBits-1:0]          root;
  logic signed [SampleBits-1:0] rt_num;

  ata_sqrt u_sqrt (
    .clk(clk), .rst(rst), .en(en), .in_valid(sq_valid), .sq(sum), .num(n_q),
    .out_valid(rt_valid), .root(root), .num_out(rt_num)
  );

  ata_cordic u_cordic (
    .clk(clk), .rst(rst), .en(en), .in_valid(rt_valid), .mag(root), .num(rt_num),
    .out_valid(out_valid), .angle(angle)
  );

endmodule

@@ rtl/core/accel_tilt_angles_core.sv @@
// Tilt angle core: roll and pitch from one accelerometer sample.
// The path runs through the square registers, the square root stages, the CORDIC stages and the output register.
// Throughput is one sample per cycle while the output is not stalled: square root and CORDIC are fully pipelined.
// A stall on the output freezes the whole pipeline; the output register holds its transfer.
// Synchronous active-high reset clears all valid bits; payload registers are not reset.
// Depends on ata_pkg, ata_tilt and the assertion macros header.
`include "accel_tilt_angles_core_macros.svh"
module accel_tilt_angles_core import ata_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  ata_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ata_out_t out_data
);

  // Pipeline advances whenever the output register is empty or being drained.
  logic en;
  logic acc;
  logic r_valid;
  logic p_valid;
  logic signed [AngleW-1:0] roll_raw;
  logic signed [AngleW-1:0] pitch_raw;
  logic out_stall;
  logic pitch_in_range;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign acc      = in_valid && in_ready;

  ata_tilt u_roll (
    .clk(clk), .rst(rst), .en(en), .in_valid(acc),
    .n(in_data.accel_x), .p(in_data.accel_y), .q(in_data.accel_z),
    .out_valid(r_valid), .angle(roll_raw)
  );

  ata_tilt u_pitch (
    .clk(clk), .rst(rst), .en(en), .in_valid(acc),
    .n(in_data.accel_y), .p(in_data.accel_x), .q(in_data.accel_z),
    .out_valid(p_valid), .angle(pitch_raw)
  );

  // Output register; roll is the negated tilt.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= r_valid;
    end
    if (en) begin
      out_data.roll_angle  <= -roll_raw;
      out_data.pitch_angle <= pitch_raw;
    end
  end

  // Terms used by the checks below.
  assign out_stall      = out_valid && !out_ready;
  assign pitch_in_range = (out_data.pitch_angle <= 16'sd23040) &&
                          (out_data.pitch_angle >= -16'sd23040);

  `ATA_ASSERT(a_lanes_aligned, r_valid == p_valid, "roll and pitch lanes out of step")
  `ATA_ASSERT_NEXT(a_hold_on_stall, out_stall, $stable(out_data) && out_valid, "output moved")
  `ATA_ASSERT(a_pitch_range, !out_valid || pitch_in_range, "pitch out of range")

endmodule

@@ sim/tb_accel_tilt_angles_core.sv @@
// Testbench for accel_tilt_angles_core: directed table, then random samples.
// Each output is checked against a table angle or a local fixed-point CORDIC tilt predictor.
// Depends on ata_pkg and the accel_tilt_angles_core RTL.
`timescale 1ns / 1ps
module tb_accel_tilt_angles_core;
  import ata_pkg::*;

  localparam int NumRandom = 1030;
  localparam int StallLimit = 4000;
  localparam int DrainCycles = 70;
  localparam longint RightAngle = longint'(90) << AngleFracBits;

  // atan(2^-i) in degrees, scaled by 2^24 and rounded to nearest.
  localparam longint AtanTab [CordicSteps] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
    117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229,
    115, 57, 29, 14, 7
  };

  typedef struct {
    int       x;
    int       y;
    int       z;
    bit       known;
    ata_out_t angles;
  } sample_row_t;

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_ready;
  ata_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  ata_out_t out_data;

  ata_out_t    pending_angles[$];
  sample_row_t sample_rows[$];
  int          err_count;
  int          quiet_cycles;
  bit          idling_on;
  bit          stim_done;

  accel_tilt_angles_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Exact integer square root, bit by bit.
  function automatic longint isqrt(logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] bitv;
    rem = v;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(root);
  endfunction

  // atan2(n, sqrt(p*p + q*q)) in units of 2^-AngleFracBits degree.
  function automatic longint tilt_angle(longint n, longint p, longint q);
    longint      cx;
    longint      cy;
    longint      cz;
    longint      dx;
    longint      dy;
    longint      mag;
    logic [63:0] sq;
    cz = 0;
    sq = p * p + q * q;
    if (n == 0) return 0;
    if (sq == 0) return (n > 0) ? RightAngle : -RightAngle;
    cx = isqrt(sq << 32);
    cy = n * 65536;
    for (int i = 0; i < CordicSteps; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx = cx + dx;
        cy = cy - dy;
        cz = cz + AtanTab[i];
      end else begin
        cx = cx - dx;
        cy = cy + dy;
        cz = cz - AtanTab[i];
      end
    end
    mag = (cz < 0) ? -cz : cz;
    mag = (mag + (longint'(1) << (RoundSh - 1))) >>> RoundSh;
    if (mag > RightAngle) mag = RightAngle;
    return (cz < 0) ? -mag : mag;
  endfunction

  function automatic ata_out_t predict_tilt(ata_in_t s);
    ata_out_t r;
    longint   ax;
    longint   ay;
    longint   az;
    ax = longint'(s.accel_x);
    ay = longint'(s.accel_y);
    az = longint'(s.accel_z);
    r.roll_angle = AngleW'(-tilt_angle(ax, ay, az));
    r.pitch_angle = AngleW'(tilt_angle(ay, ax, az));
    return r;
  endfunction

  function automatic sample_row_t row(int x, int y, int z, bit known, int roll, int pitch);
    sample_row_t r;
    r.x = x;
    r.y = y;
    r.z = z;
    r.known = known;
    r.angles.roll_angle = AngleW'(roll);
    r.angles.pitch_angle = AngleW'(pitch);
    return r;
  endfunction

  // Drive one sample and hold it until the transfer happens.
  task automatic send_sample(ata_in_t s, bit known, ata_out_t angles);
    while (idling_on && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_angles.push_back(known ? angles : predict_tilt(s));
  endtask

  // Output side stalls at random, except during the quiet stretch.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= idling_on ? ($urandom_range(99) >= 27) : 1'b1;
    end
  end

  // Check each output transfer and watch for a stuck pipeline.
  always @(posedge clk) begin
    ata_out_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_angles.size() == 0) begin
          $error("output transfer with no sample outstanding");
          err_count++;
        end else begin
          want = pending_angles.pop_front();
          if (out_data.roll_angle !== want.roll_angle) begin
            $error("roll_angle: expected %0d, got %0d", want.roll_angle, out_data.roll_angle);
            err_count++;
          end
          if (out_data.pitch_angle !== want.pitch_angle) begin
            $error("pitch_angle: expected %0d, got %0d", want.pitch_angle,
                   out_data.pitch_angle);
            err_count++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (stim_done && pending_angles.size() == 0)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= StallLimit) begin
          $display("tb_accel_tilt_angles_core: done, errors");
          $finish;
        end
      end
    end
  end

  initial begin
    ata_in_t  s;
    ata_out_t none;
    int       kind;
    none = '0;
    err_count = 0;
    quiet_cycles = 0;
    idling_on = 1'b1;
    stim_done = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed rows: zero numerators, zero magnitudes, extremes, 45 degrees.
    sample_rows.push_back(row(0, 0, 0, 1, 0, 0));
    sample_rows.push_back(row(0, 0, 2047, 1, 0, 0));
    sample_rows.push_back(row(0, 0, -2048, 1, 0, 0));
    sample_rows.push_back(row(2047, 0, 0, 1, -23040, 0));
    sample_rows.push_back(row(-2048, 0, 0, 1, 23040, 0));
    sample_rows.push_back(row(1, 0, 0, 1, -23040, 0));
    sample_rows.push_back(row(-1, 0, 0, 1, 23040, 0));
    sample_rows.push_back(row(0, 2047, 0, 1, 0, 23040));
    sample_rows.push_back(row(0, -2048, 0, 1, 0, -23040));
    sample_rows.push_back(row(0, -1, 0, 1, 0, -23040));
    sample_rows.push_back(row(2047, 2047, 2047, 0, 0, 0));
    sample_rows.push_back(row(-2048, -2048, -2048, 0, 0, 0));
    sample_rows.push_back(row(2047, -2048, 0, 0, 0, 0));
    sample_rows.push_back(row(1, 1, 0, 0, 0, 0));
    sample_rows.push_back(row(-1, 1, -1, 0, 0, 0));
    sample_rows.push_back(row(1, 0, 2047, 0, 0, 0));
    sample_rows.push_back(row(0, 1, -2048, 0, 0, 0));
    sample_rows.push_back(row(-2048, 1, 1, 0, 0, 0));
    sample_rows.push_back(row(1365, -1366, 682, 0, 0, 0));
    sample_rows.push_back(row(-1366, 1365, -683, 0, 0, 0));
    foreach (sample_rows[i]) begin
      s.accel_x = SampleBits'(sample_rows[i].x);
      s.accel_y = SampleBits'(sample_rows[i].y);
      s.accel_z = SampleBits'(sample_rows[i].z);
      send_sample(s, sample_rows[i].known, sample_rows[i].angles);
    end

    // Random samples: full range, small values and zeroed axes mixed.
    for (int i = 0; i < NumRandom; i++) begin
      idling_on = !(i >= 400 && i < 600);
      kind = $urandom_range(99);
      s.accel_x = SampleBits'($urandom);
      s.accel_y = SampleBits'($urandom);
      s.accel_z = SampleBits'($urandom);
      if (kind < 15) begin
        s.accel_x = SampleBits'($urandom_range(8) - 4);
        s.accel_y = SampleBits'($urandom_range(8) - 4);
        s.accel_z = SampleBits'($urandom_range(8) - 4);
      end else if (kind < 35) begin
        if ($urandom_range(1)) s.accel_x = '0;
        if ($urandom_range(1)) s.accel_y = '0;
        if ($urandom_range(1)) s.accel_z = '0;
      end
      send_sample(s, 1'b0, none);
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;

    while (pending_angles.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_accel_tilt_angles_core: done, clean");
    end else begin
      $display("tb_accel_tilt_angles_core: done, errors");
    end
    $finish;
  end

endmodule
